### design/pktsig_pkg.sv
// Package for the packet signer: beat types, register codes and MD4 step tables.
package pktsig_pkg;

  localparam int CNT_W  = 6;
  localparam int STEP_W = 6;
  localparam int WPOS_W = 4;

  localparam logic [STEP_W-1:0] LAST_STEP = 6'd47;

  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [1:0] REG_ROOT     = 2'd0;
  localparam logic [1:0] REG_CHAIN_LO = 2'd1;
  localparam logic [1:0] REG_CHAIN_HI = 2'd2;

  localparam logic [1:0] RND_SEL = 2'd0;
  localparam logic [1:0] RND_MAJ = 2'd1;
  localparam logic [1:0] RND_XOR = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  data_byte;
    logic [15:0] packet_size;
    logic        last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] signature;
    logic [16:0] signed_size;
  } out_beat_t;

  typedef struct packed {
    logic              wr_en;
    logic [CNT_W-1:0]  wr_pos;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [WPOS_W-1:0] rd_pos;
  } msg_ctl_t;

  // message word index used by a step
  function automatic logic [3:0] step_msg(input logic [STEP_W-1:0] step);
    logic [3:0] idx;
    case (step[5:4])
      RND_SEL: idx = step[3:0];
      RND_MAJ: idx = {step[1:0], step[3:2]};
      RND_XOR: idx = {step[0], step[1], step[2], step[3]};
      default: idx = 4'd0;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] step_shift(input logic [STEP_W-1:0] step);
    logic [4:0] sh;
    sh = 5'd3;
    case (step[5:4])
      RND_SEL: begin
        case (step[1:0])
          2'd0:    sh = 5'd3;
          2'd1:    sh = 5'd7;
          2'd2:    sh = 5'd11;
          default: sh = 5'd19;
        endcase
      end
      RND_MAJ: begin
        case (step[1:0])
          2'd0:    sh = 5'd3;
          2'd1:    sh = 5'd5;
          2'd2:    sh = 5'd9;
          default: sh = 5'd13;
        endcase
      end
      default: begin
        case (step[1:0])
          2'd0:    sh = 5'd3;
          2'd1:    sh = 5'd9;
          2'd2:    sh = 5'd11;
          default: sh = 5'd15;
        endcase
      end
    endcase
    return sh;
  endfunction

  function automatic logic [31:0] step_const(input logic [STEP_W-1:0] step);
    logic [31:0] k;
    case (step[5:4])
      RND_SEL: k = 32'd0;
      RND_MAJ: k = K_ROUND2;
      default: k = K_ROUND3;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] step_fn(input logic [STEP_W-1:0] step,
                                          input logic [31:0] x,
                                          input logic [31:0] y,
                                          input logic [31:0] z);
    logic [31:0] f;
    case (step[5:4])
      RND_SEL: f = (x & y) | (~x & z);
      RND_MAJ: f = (x & y) | (x & z) | (y & z);
      default: f = x ^ y ^ z;
    endcase
    return f;
  endfunction

endpackage

### design/pktsig_msgbuf.sv
// Packet byte store: byte-lane writes, registered word reads masked to the valid length.
module pktsig_msgbuf import pktsig_pkg::*; #(
  parameter int PAYLOAD_BYTES = 52
) (
  input  logic             clk,
  input  msg_ctl_t         ctl,
  input  logic [CNT_W-1:0] vlen,
  output logic [31:0]      rd_word
);

  localparam int WORDS = (PAYLOAD_BYTES + 3) / 4;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [31:0]       mem [WORDS];
  logic [31:0]       rd_q_r;
  logic [WPOS_W-1:0] pos_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_pos[AW+1:2]][{ctl.wr_pos[1:0], 3'b000} +: 8] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem[ctl.rd_pos[AW-1:0]];
      pos_r  <= ctl.rd_pos;
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if ({pos_r, 2'(l)} < vlen) begin
        rd_word[8*l +: 8] = rd_q_r[8*l +: 8];
      end else begin
        rd_word[8*l +: 8] = 8'd0;
      end
    end
  end

endmodule

### design/pktsig_step.sv
// One MD4 step: add of function, constant and message word, then left rotate.
module pktsig_step import pktsig_pkg::*; (
  input  logic [STEP_W-1:0] step,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  logic [31:0]       c,
  input  logic [31:0]       d,
  input  logic [31:0]       m,
  output logic [31:0]       q
);

  logic [31:0] sum;
  logic [63:0] rot;

  always_comb begin
    sum = a + step_fn(step, b, c, d) + step_const(step) + m;
    rot = {sum, sum} << step_shift(step);
    q   = rot[63:32];
  end

endmodule

### design/packet_signature_md4.sv
// Packet signer top level: byte capture, APB registers and the step sequencer.
// Bytes are taken one per cycle while the block is idle; the beat marked last stalls input
// through the load state, 48 MD4 steps through the single shared step adder and
// one chain add, which waits while an earlier result is still held and stalled. The
// result is registered with the new chain value and held until taken.
// Reset is synchronous, active low; registers and the chain value clear to zero.
module packet_signature_md4 import pktsig_pkg::*; #(
  parameter int PAYLOAD_BYTES = 52,
  parameter int HEADER_BYTES  = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_STEP, ST_FINISH} state_t;

  state_t            state_r;
  logic [63:0]       root_r, start_lo_r, start_hi_r;
  logic [127:0]      chain_r;
  logic [31:0]       a_r, b_r, c_r, d_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  cnt_r, vlen_r;
  logic [15:0]       held_r;
  logic [3:0]        msg_idx_r;
  logic              out_valid_r;
  out_beat_t         out_beat_r;

  logic              in_acc, cfg_wr, out_free;
  logic [CNT_W-1:0]  cnt_nxt, vlen_nxt;
  logic [16:0]       sz1, lim17;
  logic [CNT_W-1:0]  lim;
  logic [3:0]        iss_idx;
  logic [31:0]       m_word, mem_word, q;
  msg_ctl_t          ctl;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;
  assign out_free  = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r     <= '0;
      start_lo_r <= '0;
      start_hi_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_ROOT:     root_r     <= pwdata;
        REG_CHAIN_LO: start_lo_r <= pwdata;
        REG_CHAIN_HI: start_hi_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_ROOT:     prdata = root_r;
      REG_CHAIN_LO: prdata = start_lo_r;
      REG_CHAIN_HI: prdata = start_hi_r;
      default:      prdata = 64'd0;
    endcase
  end

  // bytes held and the payload length from the size field
  always_comb begin
    cnt_nxt = (cnt_r < CNT_W'(PAYLOAD_BYTES)) ? cnt_r + CNT_W'(1) : cnt_r;
    sz1     = {1'b0, in_beat.packet_size} + 17'd1;
    lim17   = (sz1 >= 17'(HEADER_BYTES)) ? sz1 - 17'(HEADER_BYTES) : 17'd0;
    lim     = (lim17 > 17'(PAYLOAD_BYTES)) ? CNT_W'(PAYLOAD_BYTES) : lim17[CNT_W-1:0];
    vlen_nxt = (cnt_nxt < lim) ? cnt_nxt : lim;
  end

  always_comb begin
    iss_idx     = step_msg((state_r == ST_LOAD) ? '0 : step_r + STEP_W'(1));
    ctl.wr_en   = in_acc & (in_beat.opcode == OP_BYTE) & (cnt_r < CNT_W'(PAYLOAD_BYTES));
    ctl.wr_pos  = cnt_r;
    ctl.wr_data = in_beat.data_byte;
    ctl.rd_en   = (state_r == ST_LOAD) | (state_r == ST_STEP);
    ctl.rd_pos  = iss_idx - 4'd3;
  end

  pktsig_msgbuf #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_msgbuf (
    .clk     (clk),
    .ctl     (ctl),
    .vlen    (vlen_r),
    .rd_word (mem_word)
  );

  always_comb begin
    case (msg_idx_r)
      4'd0:    m_word = root_r[31:0];
      4'd1:    m_word = root_r[63:32];
      4'd2:    m_word = {16'd0, held_r};
      default: m_word = mem_word;
    endcase
  end

  pktsig_step u_step (
    .step (step_r),
    .a    (a_r),
    .b    (b_r),
    .c    (c_r),
    .d    (d_r),
    .m    (m_word),
    .q    (q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.rd_en) begin
        msg_idx_r <= iss_idx;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_beat.opcode == OP_RESTART) begin
              chain_r <= {start_hi_r, start_lo_r};
              cnt_r   <= '0;
            end else if (in_beat.last_byte) begin
              vlen_r  <= vlen_nxt;
              held_r  <= in_beat.packet_size;
              cnt_r   <= '0;
              state_r <= ST_LOAD;
            end else begin
              cnt_r <= cnt_nxt;
            end
          end
        end
        ST_LOAD: begin
          {d_r, c_r, b_r, a_r} <= chain_r;
          step_r  <= '0;
          state_r <= ST_STEP;
        end
        ST_STEP: begin
          a_r <= d_r;
          b_r <= q;
          c_r <= b_r;
          d_r <= c_r;
          step_r <= step_r + STEP_W'(1);
          if (step_r == LAST_STEP) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            chain_r <= {chain_r[127:96] + d_r, chain_r[95:64] + c_r,
                        chain_r[63:32] + b_r, chain_r[31:0] + a_r};
            out_beat_r.signature   <= {chain_r[63:32] + b_r, chain_r[31:0] + a_r};
            out_beat_r.signed_size <= {1'b0, held_r} + 17'd8;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside chain update");

  a_chain_source: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(chain_r) |-> $past(state_r == ST_FINISH ||
                                (in_acc && in_beat.opcode == OP_RESTART)))
    else $error("chain value changed without restart or signing");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (step_r <= LAST_STEP))
    else $error("step counter overran");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == ST_FINISH) |=> $stable(out_beat_r))
    else $error("pending result overwritten");

endmodule

### verif/packet_signature_md4_tb.sv
// Self-checking testbench for packet_signature_md4: packet beats in, checked signatures out.
module packet_signature_md4_tb;
  import pktsig_pkg::*;

  localparam int PAYLOAD_BYTES = 52;
  localparam int HEADER_BYTES  = 7;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int R3_ORDER[4]   = '{0, 2, 1, 3};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // signer state as the block should hold it
  logic [63:0] root_key = '0;
  logic [63:0] start_lo = '0;
  logic [63:0] start_hi = '0;
  logic [63:0] chain_lo = '0;
  logic [63:0] chain_hi = '0;
  logic [7:0]  msg_bytes[PAYLOAD_BYTES];
  int          nbytes = 0;
  logic [15:0] last_size = '0;

  out_beat_t   pending_sigs[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          rx_burst_left = 0;

  packet_signature_md4 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  function automatic logic [31:0] rol32(logic [31:0] x, int c);
    return (x << c) | (x >> (32 - c));
  endfunction

  function automatic logic [31:0] f_sel(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return (x & y) | (~x & z);
  endfunction

  function automatic logic [31:0] f_maj(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return (x & y) | (x & z) | (y & z);
  endfunction

  function automatic void clear_capture();
    foreach (msg_bytes[i]) msg_bytes[i] = 8'h00;
    nbytes = 0;
  endfunction

  function automatic void md4_chain_update(int keep);
    logic [31:0] w[16];
    logic [7:0]  pay[PAYLOAD_BYTES];
    logic [31:0] a, b, c, d;
    int          i, r;
    for (i = 0; i < PAYLOAD_BYTES; i++) pay[i] = (i < keep) ? msg_bytes[i] : 8'h00;
    w[0] = root_key[31:0];
    w[1] = root_key[63:32];
    w[2] = {16'h0000, last_size};
    for (i = 0; i < 13; i++)
      w[3 + i] = {pay[4*i+3], pay[4*i+2], pay[4*i+1], pay[4*i]};
    a = chain_lo[31:0];
    b = chain_lo[63:32];
    c = chain_hi[31:0];
    d = chain_hi[63:32];
    for (i = 0; i < 16; i += 4) begin
      a = rol32(a + f_sel(b, c, d) + w[i], 3);
      d = rol32(d + f_sel(a, b, c) + w[i+1], 7);
      c = rol32(c + f_sel(d, a, b) + w[i+2], 11);
      b = rol32(b + f_sel(c, d, a) + w[i+3], 19);
    end
    for (i = 0; i < 4; i++) begin
      a = rol32(a + f_maj(b, c, d) + K_ROUND2 + w[i], 3);
      d = rol32(d + f_maj(a, b, c) + K_ROUND2 + w[i+4], 5);
      c = rol32(c + f_maj(d, a, b) + K_ROUND2 + w[i+8], 9);
      b = rol32(b + f_maj(c, d, a) + K_ROUND2 + w[i+12], 13);
    end
    for (i = 0; i < 4; i++) begin
      r = R3_ORDER[i];
      a = rol32(a + (b ^ c ^ d) + K_ROUND3 + w[r], 3);
      d = rol32(d + (a ^ b ^ c) + K_ROUND3 + w[r+8], 9);
      c = rol32(c + (d ^ a ^ b) + K_ROUND3 + w[r+4], 11);
      b = rol32(b + (c ^ d ^ a) + K_ROUND3 + w[r+12], 15);
    end
    chain_lo = {chain_lo[63:32] + b, chain_lo[31:0] + a};
    chain_hi = {chain_hi[63:32] + d, chain_hi[31:0] + c};
  endfunction

  function automatic void predict_signature(in_beat_t beat);
    int        keep;
    out_beat_t sig;
    if (beat.opcode == OP_RESTART) begin
      chain_lo = start_lo;
      chain_hi = start_hi;
      clear_capture();
      return;
    end
    if (nbytes < PAYLOAD_BYTES) begin
      msg_bytes[nbytes] = beat.data_byte;
      nbytes++;
    end
    last_size = beat.packet_size;
    if (!beat.last_byte) return;
    keep = int'(beat.packet_size) + 1 - HEADER_BYTES;
    if (keep < 0) keep = 0;
    if (keep > PAYLOAD_BYTES) keep = PAYLOAD_BYTES;
    md4_chain_update(keep);
    sig.signature   = chain_lo;
    sig.signed_size = 17'(last_size) + 17'd8;
    pending_sigs.push_back(sig);
    clear_capture();
  endfunction

  function automatic in_beat_t mk_beat(logic op, logic [7:0] data, logic [15:0] size,
                                       logic last);
    in_beat_t beat;
    beat.opcode      = op;
    beat.data_byte   = data;
    beat.packet_size = size;
    beat.last_byte   = last;
    return beat;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sigs.size() == 0) begin
        note_mismatch("unexpected result beat", 64'h0, out_beat.signature);
      end else begin
        want = pending_sigs.pop_front();
        if (out_beat.signature !== want.signature)
          note_mismatch("signature", want.signature, out_beat.signature);
        if (out_beat.signed_size !== want.signed_size)
          note_mismatch("signed_size", 64'(want.signed_size), 64'(out_beat.signed_size));
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_burst_left > 0) begin
      out_stall <= 1'b1;
      rx_burst_left--;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      rx_burst_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_beat(in_beat_t beat);
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (in_stall);
    predict_signature(beat);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_sigs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROOT:     root_key = value;
      REG_CHAIN_LO: start_lo = value;
      REG_CHAIN_HI: start_hi = value;
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) note_mismatch("register readback", value, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_settings(logic [63:0] root, logic [63:0] lo, logic [63:0] hi);
    wait_results_done();
    write_reg(REG_ROOT, root);
    write_reg(REG_CHAIN_LO, lo);
    write_reg(REG_CHAIN_HI, hi);
    send_beat(mk_beat(OP_RESTART, 8'h00, 16'h0000, 1'b0));
  endtask

  task automatic send_random_packets(int budget);
    int          kind, len, i, pick;
    logic [15:0] size;
    while (budget > 0) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        send_beat(mk_beat(1'($urandom), 8'($urandom), 16'($urandom), 1'($urandom)));
        budget--;
      end else if (kind == 2) begin
        send_beat(mk_beat(OP_RESTART, 8'($urandom), 16'($urandom), 1'($urandom)));
        budget--;
      end else begin
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 14);
        pick = $urandom_range(0, 9);
        if (pick < 6) size = 16'(len + HEADER_BYTES - 1);
        else if (pick < 8) size = 16'($urandom);
        else size = 16'($urandom_range(0, 12));
        for (i = 0; i < len; i++) begin
          // kind 3: packet cut short by a restart
          if (kind == 3 && i == len - 1)
            send_beat(mk_beat(OP_RESTART, 8'($urandom), size, 1'b1));
          else
            send_beat(mk_beat(OP_BYTE, 8'($urandom), size, 1'(i == len - 1)));
          budget--;
        end
      end
    end
  endtask

  task automatic test_edge_packets();
    // size below the header: nothing kept
    send_beat(mk_beat(OP_BYTE, 8'hff, 16'd0, 1'b1));
    send_beat(mk_beat(OP_BYTE, 8'hff, 16'd5, 1'b1));
    // size one short of a payload byte: nothing kept
    send_beat(mk_beat(OP_BYTE, 8'h80, 16'd6, 1'b1));
    // largest size, short packet
    send_beat(mk_beat(OP_BYTE, 8'h00, 16'hffff, 1'b0));
    send_beat(mk_beat(OP_BYTE, 8'hff, 16'hffff, 1'b1));
    send_beat(mk_beat(OP_BYTE, 8'h12, 16'd8, 1'b0));
    send_beat(mk_beat(OP_BYTE, 8'h34, 16'd8, 1'b0));
    send_beat(mk_beat(OP_BYTE, 8'h56, 16'd8, 1'b1));
    // packet dropped by a restart carrying live fields
    send_beat(mk_beat(OP_BYTE, 8'haa, 16'd9, 1'b0));
    send_beat(mk_beat(OP_BYTE, 8'h55, 16'd9, 1'b0));
    send_beat(mk_beat(OP_RESTART, 8'hff, 16'hffff, 1'b1));
    // more bytes than the size allows: tail zeroed
    send_beat(mk_beat(OP_BYTE, 8'h01, 16'd7, 1'b0));
    send_beat(mk_beat(OP_BYTE, 8'h02, 16'd7, 1'b0));
    send_beat(mk_beat(OP_BYTE, 8'h03, 16'd7, 1'b0));
    send_beat(mk_beat(OP_BYTE, 8'h04, 16'd7, 1'b1));
  endtask

  task automatic test_random_traffic();
    load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_packets(480);
    load_settings('1, '1, '1);
    send_random_packets(480);
    // register write alone leaves the chain untouched until restart
    wait_results_done();
    write_reg(REG_CHAIN_LO, {$urandom, $urandom});
    send_random_packets(60);
    load_settings('0, '0, '0);
    send_random_packets(420);
  endtask

  task automatic test_receiver_holdoff();
    int i;
    load_settings({$urandom, $urandom}, '1, '0);
    hold_req = 1'b1;
    for (i = 0; i < 6; i++)
      send_beat(mk_beat(OP_BYTE, 8'($urandom), 16'($urandom_range(0, 70)), 1'b1));
    wait_results_done();
    send_beat(mk_beat(OP_BYTE, 8'($urandom), 16'd6, 1'b1));
    wait_results_done();
  endtask

  task automatic test_steady_stream();
    wait_results_done();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random_packets(280);
  endtask

  initial begin
    clear_capture();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_edge_packets();
    test_random_traffic();
    test_receiver_holdoff();
    test_steady_stream();
    wait_results_done();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### packet_signature_md4.f
design/pktsig_pkg.sv
design/pktsig_msgbuf.sv
design/pktsig_step.sv
design/packet_signature_md4.sv
verif/packet_signature_md4_tb.sv
